>>> design/modular_exponentiation_defines.svh
// assertion macros for the modular exponentiation block
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

`ifndef SYNTH
`define MEXP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MEXP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MEXP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MEXP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/mexp_pkg.sv
package mexp_pkg;

  localparam int BASE_W        = 32;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int DEF_MOD_WIDTH = 31;
  localparam int DEF_EXP_WIDTH = 32;
  localparam int CNT_W         = $clog2(BASE_W);

  localparam logic [CFG_DATA_W-1:0] RESET_EXPONENT = 32'd17;
  localparam logic [CFG_DATA_W-1:0] RESET_MODULUS  = 32'd3233;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPONENT = 2'd0,
    REG_MODULUS  = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_LOAD,
    S_STEP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic en;
  } lane_ctrl_t;

endpackage

>>> design/mexp_lane.sv
module mexp_lane #(
  parameter int MOD_WIDTH = mexp_pkg::DEF_MOD_WIDTH
) (
  input  logic                 clk,
  input  mexp_pkg::lane_ctrl_t lctl,
  input  logic                 bit_in,
  input  logic [MOD_WIDTH-1:0] multiplicand,
  input  logic [MOD_WIDTH-1:0] modulus,
  output logic [MOD_WIDTH-1:0] product
);
  import mexp_pkg::*;

  logic [MOD_WIDTH-1:0] p_r, p_nxt;
  logic [MOD_WIDTH:0]   mod_x, dbl, dbl_red, sum, sum_red;

  // one multiplier bit per cycle while en is set, msb first: p = 2p + bit*a, reduced twice
  always_comb begin
    mod_x   = {1'b0, modulus};
    dbl     = {p_r, 1'b0};
    dbl_red = (dbl >= mod_x) ? (dbl - mod_x) : dbl;
    sum     = {1'b0, dbl_red[MOD_WIDTH-1:0]}
              + (bit_in ? {1'b0, multiplicand} : {(MOD_WIDTH+1){1'b0}});
    sum_red = (sum >= mod_x) ? (sum - mod_x) : sum;
    p_nxt   = lctl.clear ? {MOD_WIDTH{1'b0}} : sum_red[MOD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (lctl.clear || lctl.en) begin
      p_r <= p_nxt;
    end
  end

  assign product = p_r;

endmodule

>>> design/modular_exponentiation.sv
// Modular exponentiation: out_power_result = in_base_value ** exponent mod modulus,
// right-to-left square and multiply. One item is worked on at a time. The base is
// first reduced bit-serially, then each exponent bit up to the highest set one is
// worked on with the multiply and the square running side by side in two
// bit-serial shift-add lanes that consume one multiplier bit a cycle. A zero
// exponent gives 1, and a modulus below 2 gives 0 without any lane pass. A new item
// is taken as soon as the previous result sits in the output register. Registers:
// index 0 exponent, index 1 modulus; write them only while the block is idle.
`include "modular_exponentiation_defines.svh"

module modular_exponentiation #(
  parameter int MOD_WIDTH = mexp_pkg::DEF_MOD_WIDTH,
  parameter int EXP_WIDTH = mexp_pkg::DEF_EXP_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mexp_pkg::BASE_W-1:0]     in_base_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [MOD_WIDTH-1:0]            out_power_result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mexp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mexp_pkg::*;

  state_t               state_r, state_nxt;
  lane_ctrl_t           lctl;
  logic [EXP_WIDTH-1:0] exp_r, expsh_r, exp_new;
  logic [MOD_WIDTH-1:0] mod_r, b_r, acc_r, b_new, acc_new, pa, ps;
  logic [BASE_W-1:0]    sh_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 first_r, out_valid_r, mod_small, in_acc, out_free;
  logic [MOD_WIDTH-1:0] out_data_r;

  assign mod_small = mod_r < MOD_WIDTH'(2);
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_power_result = out_data_r;

  // after reduction only the base is taken; a step lands ps, and pa if exp bit set
  assign b_new   = first_r ? pa : ps;
  assign exp_new = first_r ? expsh_r : (expsh_r >> 1);
  assign acc_new = (!first_r && expsh_r[0]) ? pa : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= EXP_WIDTH'(RESET_EXPONENT);
      mod_r <= MOD_WIDTH'(RESET_MODULUS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_EXPONENT: exp_r <= cfg_data[EXP_WIDTH-1:0];
        REG_MODULUS:  mod_r <= cfg_data[MOD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lctl      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          lctl.clear = 1'b1;
          state_nxt  = mod_small ? S_FINISH : S_REDUCE;
        end
      end
      S_REDUCE: begin
        lctl.en = 1'b1;
        if (cnt_r == '0) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        lctl.clear = 1'b1;
        state_nxt  = (exp_new == '0) ? S_FINISH : S_STEP;
      end
      S_STEP: begin
        lctl.en = 1'b1;
        if (cnt_r == '0) state_nxt = S_LOAD;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          sh_r    <= in_base_value;
          cnt_r   <= CNT_W'(BASE_W - 1);
          // acc is the multiplicand of lane a, so 1 turns it into a plain reducer
          acc_r   <= mod_small ? {MOD_WIDTH{1'b0}} : MOD_WIDTH'(1);
          expsh_r <= exp_r;
          first_r <= 1'b1;
        end
      end
      S_REDUCE, S_STEP: begin
        sh_r  <= sh_r << 1;
        cnt_r <= cnt_r - 1'b1;
      end
      S_LOAD: begin
        b_r     <= b_new;
        acc_r   <= acc_new;
        expsh_r <= exp_new;
        first_r <= 1'b0;
        sh_r    <= BASE_W'(b_new) << (BASE_W - MOD_WIDTH);
        cnt_r   <= CNT_W'(MOD_WIDTH - 1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FINISH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FINISH && out_free) begin
      out_data_r <= acc_r;
    end
  end

  // lane a: acc * base (or base reduction), lane s: base * base
  mexp_lane #(.MOD_WIDTH(MOD_WIDTH)) u_lane_a (
    .clk          (clk),
    .lctl         (lctl),
    .bit_in       (sh_r[BASE_W-1]),
    .multiplicand (acc_r),
    .modulus      (mod_r),
    .product      (pa)
  );

  mexp_lane #(.MOD_WIDTH(MOD_WIDTH)) u_lane_s (
    .clk          (clk),
    .lctl         (lctl),
    .bit_in       (sh_r[BASE_W-1]),
    .multiplicand (b_r),
    .modulus      (mod_r),
    .product      (ps)
  );

  `MEXP_ASSERT_IMP(a_out_range, clk, rst_n, out_valid_r && !mod_small, out_data_r < mod_r)
  `MEXP_ASSERT_IMP(a_ops_range, clk, rst_n, state_r == S_STEP, (acc_r < mod_r) && (b_r < mod_r))
  `MEXP_ASSERT_IMP(a_lane_range, clk, rst_n, state_r == S_STEP, (pa < mod_r) && (ps < mod_r))
  `MEXP_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && in_ready, state_r != S_IDLE)

endmodule
